/* hdl/wtbg_pkg.sv */
// Shared types, constants and table functions for the windowed tone burst generator.
package wtbg_pkg;

  localparam int unsigned LUT_ADDR_BITS_DEF = 10;
  localparam int unsigned INDEX_BITS_DEF    = 16;

  localparam int unsigned SAMPLE_W   = 15;
  localparam int unsigned SIDX_W     = 16;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned HWIDTH_W   = 15;
  localparam int unsigned SCALE_W    = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned MUL_A_W = 45;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned PROD_SHIFT = 46;

  localparam logic [SIDX_W-1:0]     TOTAL_SAMPLES_RST = 16'd16000;
  localparam logic [PHASE_W-1:0]    TONE_STEP_RST     = 32'd268435456;
  localparam logic [SIDX_W-1:0]     BURST_CENTER_RST  = 16'd8000;
  localparam logic [HWIDTH_W-1:0]   HALF_WIDTH_RST    = 15'd3200;
  localparam logic [PHASE_W-1:0]    ENV_STEP_RST      = 32'd335544;
  localparam logic [SCALE_W-1:0]    PEAK_SCALE_RST    = 15'd16383;

  localparam logic [PHASE_W-1:0]    QUARTER_TURN = 32'h4000_0000;
  localparam logic [63:0]           HALF_PI_Q30  = 64'd1686629713;
  localparam logic [63:0]           TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                       64'd110, 64'd156};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_SAMPLES = 3'd0,
    REG_TONE_STEP     = 3'd1,
    REG_BURST_CENTER  = 3'd2,
    REG_HALF_WIDTH    = 3'd3,
    REG_ENV_STEP      = 3'd4,
    REG_PEAK_SCALE    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MUL_ANGLE,
    MUL_ENVELOPE,
    MUL_SCALE,
    MUL_SAMPLE
  } mul_sel_t;

  typedef struct packed {
    logic     start;
    mul_sel_t mul_sel;
    logic     rom_cos;
    logic     cap_angle;
    logic     cap_sine;
    logic     cap_env;
    logic     cap_scaled;
    logic     out_load;
  } wtbg_cmd_t;

  // Sine of x in Q30 radians over the first quadrant, result in Q0.15.
  function automatic logic [SAMPLE_W-1:0] fixed_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int i = 0; i < 6; i++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[i];
      if ((i % 2) == 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32767) begin
      sum = 64'sd32767;
    end
    return SAMPLE_W'(sum);
  endfunction

  function automatic logic [SAMPLE_W-1:0] quarter_entry(input int unsigned k,
                                                        input int unsigned addr_bits);
    return fixed_sine((64'(k) * HALF_PI_Q30) >> addr_bits);
  endfunction

endpackage

/* hdl/wtbg_rom.sv */
// Quarter-wave sine table with a registered read port.
module wtbg_rom #(
  parameter int unsigned LUT_ADDR_BITS = wtbg_pkg::LUT_ADDR_BITS_DEF
) (
  input  logic                             clk,
  input  logic [LUT_ADDR_BITS:0]           rd_addr,
  output logic [wtbg_pkg::SAMPLE_W-1:0]    rd_data_r
);
  import wtbg_pkg::*;

  localparam int unsigned LUT_SIZE = 1 << LUT_ADDR_BITS;

  logic [SAMPLE_W-1:0] sine_tbl [LUT_SIZE+1];

  for (genvar k = 0; k <= LUT_SIZE; k++) begin : g_entry
    assign sine_tbl[k] = quarter_entry(k, LUT_ADDR_BITS);
  end

  always_ff @(posedge clk) begin
    rd_data_r <= sine_tbl[rd_addr];
  end

endmodule

/* hdl/wtbg_ctrl.sv */
// Controller that sequences one item through the shared multiplier and table.
module wtbg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output wtbg_pkg::wtbg_cmd_t cmd
);
  import wtbg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ANGLE,
    S_COS,
    S_ENV,
    S_SCALE,
    S_SAMPLE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd            = '0;
    cmd.mul_sel    = MUL_ANGLE;
    state_nxt      = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.start = in_valid;
        if (in_valid) begin
          state_nxt = S_ANGLE;
        end
      end
      S_ANGLE: begin
        cmd.mul_sel   = MUL_ANGLE;
        cmd.cap_angle = 1'b1;
        state_nxt     = S_COS;
      end
      S_COS: begin
        cmd.rom_cos  = 1'b1;
        cmd.cap_sine = 1'b1;
        state_nxt    = S_ENV;
      end
      S_ENV: begin
        cmd.mul_sel = MUL_ENVELOPE;
        cmd.cap_env = 1'b1;
        state_nxt   = S_SCALE;
      end
      S_SCALE: begin
        cmd.mul_sel    = MUL_SCALE;
        cmd.cap_scaled = 1'b1;
        state_nxt      = S_SAMPLE;
      end
      S_SAMPLE: begin
        cmd.mul_sel  = MUL_SAMPLE;
        cmd.out_load = !out_valid_r || out_ready;
        if (cmd.out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_start_enters_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_ANGLE))
    else $error("accepted item did not start the angle step");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result load did not raise out_valid");

  a_stall_holds_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SAMPLE && out_valid_r && !out_ready) |=> (state_r == S_SAMPLE))
    else $error("finished item left the sample step while the output was full");

  a_one_capture: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.cap_angle, cmd.cap_sine, cmd.cap_env, cmd.cap_scaled, cmd.out_load}))
    else $error("more than one datapath capture in one cycle");

endmodule

/* hdl/wtbg_dp.sv */
// Datapath: configuration registers, counters, shared multiplier and result register.
module wtbg_dp #(
  parameter int unsigned LUT_ADDR_BITS = wtbg_pkg::LUT_ADDR_BITS_DEF,
  parameter int unsigned INDEX_BITS    = wtbg_pkg::INDEX_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [wtbg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wtbg_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_restart,
  input  wtbg_pkg::wtbg_cmd_t                   cmd,
  output logic signed [wtbg_pkg::SAMPLE_W-1:0]  out_sample,
  output logic [wtbg_pkg::SIDX_W-1:0]           out_sample_index,
  output logic                                  out_last
);
  import wtbg_pkg::*;

  localparam logic [LUT_ADDR_BITS:0] LUT_END = (LUT_ADDR_BITS+1)'(1 << LUT_ADDR_BITS);

  logic [SIDX_W-1:0]   total_samples_r;
  logic [PHASE_W-1:0]  tone_step_r;
  logic [SIDX_W-1:0]   burst_center_r;
  logic [HWIDTH_W-1:0] half_width_r;
  logic [PHASE_W-1:0]  env_step_r;
  logic [SCALE_W-1:0]  peak_scale_r;

  logic [INDEX_BITS-1:0] index_count_r;
  logic [PHASE_W-1:0]    tone_phase_r;

  logic [SIDX_W-1:0]   cur_idx_r;
  logic [PHASE_W-1:0]  cur_phase_r;
  logic [SIDX_W-1:0]   dist_r;
  logic                last_r;
  logic                in_win_r;
  logic [PHASE_W-1:0]  angle_r;
  logic [SAMPLE_W-1:0] sine_mag_r;
  logic [29:0]         env_r;
  logic [MUL_A_W-1:0]  scaled_r;

  logic [SAMPLE_W-1:0] out_sample_r;
  logic [SIDX_W-1:0]   out_index_r;
  logic                out_last_r;

  logic [INDEX_BITS-1:0] eff_idx;
  logic [PHASE_W-1:0]    eff_phase;
  logic [SIDX_W-1:0]     idx16;
  logic [SIDX_W-1:0]     last_idx;
  logic [SIDX_W-1:0]     idx_dist;

  logic [PHASE_W-1:0]       rom_phase;
  logic [LUT_ADDR_BITS-1:0] rom_pos;
  logic [LUT_ADDR_BITS:0]   rom_addr;
  logic [SAMPLE_W-1:0]      rom_data;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [SAMPLE_W-1:0] mag;
  logic [SAMPLE_W-1:0] sample_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_samples_r <= TOTAL_SAMPLES_RST;
      tone_step_r     <= TONE_STEP_RST;
      burst_center_r  <= BURST_CENTER_RST;
      half_width_r    <= HALF_WIDTH_RST;
      env_step_r      <= ENV_STEP_RST;
      peak_scale_r    <= PEAK_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOTAL_SAMPLES: total_samples_r <= cfg_data[SIDX_W-1:0];
        REG_TONE_STEP:     tone_step_r     <= cfg_data[PHASE_W-1:0];
        REG_BURST_CENTER:  burst_center_r  <= cfg_data[SIDX_W-1:0];
        REG_HALF_WIDTH:    half_width_r    <= cfg_data[HWIDTH_W-1:0];
        REG_ENV_STEP:      env_step_r      <= cfg_data[PHASE_W-1:0];
        REG_PEAK_SCALE:    peak_scale_r    <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    eff_idx   = in_restart ? '0 : index_count_r;
    eff_phase = in_restart ? '0 : tone_phase_r;
    idx16     = SIDX_W'(eff_idx);
    last_idx  = total_samples_r - 16'd1;
    idx_dist  = (idx16 >= burst_center_r) ? (idx16 - burst_center_r)
                                          : (burst_center_r - idx16);
  end

  // Frame counters advance as soon as an item is taken and wrap to zero after the last sample index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_count_r <= '0;
      tone_phase_r  <= '0;
    end else if (cmd.start) begin
      if (idx16 >= last_idx) begin
        index_count_r <= '0;
        tone_phase_r  <= '0;
      end else begin
        index_count_r <= INDEX_BITS'(eff_idx + 1'b1);
        tone_phase_r  <= eff_phase + tone_step_r;
      end
    end
  end

  always_comb begin
    rom_phase = cmd.rom_cos ? (angle_r + QUARTER_TURN) : cur_phase_r;
    rom_pos   = rom_phase[PHASE_W-3 -: LUT_ADDR_BITS];
    rom_addr  = rom_phase[PHASE_W-2] ? (LUT_END - {1'b0, rom_pos}) : {1'b0, rom_pos};
  end

  wtbg_rom #(
    .LUT_ADDR_BITS(LUT_ADDR_BITS)
  ) u_rom (
    .clk      (clk),
    .rd_addr  (rom_addr),
    .rd_data_r(rom_data)
  );

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_ANGLE: begin
        mul_a = MUL_A_W'(env_step_r);
        mul_b = dist_r;
      end
      MUL_ENVELOPE: begin
        mul_a = MUL_A_W'(rom_data);
        mul_b = MUL_B_W'(rom_data);
      end
      MUL_SCALE: begin
        mul_a = MUL_A_W'(env_r);
        mul_b = MUL_B_W'(peak_scale_r);
      end
      MUL_SAMPLE: begin
        mul_a = scaled_r;
        mul_b = MUL_B_W'(sine_mag_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p      = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    mag        = mul_p[PROD_SHIFT +: SAMPLE_W];
    sample_val = cur_phase_r[PHASE_W-1] ? SAMPLE_W'(-mag) : mag;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_idx_r   <= idx16;
      cur_phase_r <= eff_phase;
      dist_r      <= idx_dist;
      last_r      <= (idx16 == last_idx);
    end
    if (cmd.cap_angle) begin
      angle_r  <= mul_p[PHASE_W-1:0];
      in_win_r <= (dist_r <= SIDX_W'(half_width_r));
    end
    if (cmd.cap_sine) begin
      sine_mag_r <= rom_data;
    end
    if (cmd.cap_env) begin
      env_r <= mul_p[29:0];
    end
    if (cmd.cap_scaled) begin
      scaled_r <= mul_p[MUL_A_W-1:0];
    end
    if (cmd.out_load) begin
      out_sample_r <= in_win_r ? sample_val : '0;
      out_index_r  <= cur_idx_r;
      out_last_r   <= last_r;
    end
  end

  assign out_sample       = signed'(out_sample_r);
  assign out_sample_index = out_index_r;
  assign out_last         = out_last_r;

endmodule

/* hdl/windowed_tone_burst_generator_top.sv */
// Top level of the Hann-windowed tone burst generator.
//
// Each item on the input channel (in_valid/in_ready, field in_restart) asks
// for one audio sample. With in_restart high the frame restarts at sample
// index zero and tone phase zero before the sample is made. The result item
// (out_valid/out_ready) carries out_sample, out_sample_index and out_last.
// An item is accepted in the idle state and then passes through five steps
// that share a single multiplier and one read port of the quarter-wave sine
// table; no new item is accepted until the sample step loads the result
// into the output register. The result waits there while the next item is
// accepted; if the receiver stalls, that item holds in its last step until
// the register frees. Configuration writes (cfg_valid/cfg_ready, cfg_index,
// cfg_data) are always ready and take effect at once; the user must make
// them only while the block is idle; the block itself does not enforce this.
// Synchronous reset loads the default configuration and clears the sample
// index and tone phase; no clearing pass is needed.
module windowed_tone_burst_generator_top #(
  parameter int unsigned LUT_ADDR_BITS = wtbg_pkg::LUT_ADDR_BITS_DEF,
  parameter int unsigned INDEX_BITS    = wtbg_pkg::INDEX_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_restart,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [wtbg_pkg::SAMPLE_W-1:0]  out_sample,
  output logic [wtbg_pkg::SIDX_W-1:0]           out_sample_index,
  output logic                                  out_last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wtbg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wtbg_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import wtbg_pkg::*;

  wtbg_cmd_t cmd;

  assign cfg_ready = 1'b1;

  wtbg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  wtbg_dp #(
    .LUT_ADDR_BITS(LUT_ADDR_BITS),
    .INDEX_BITS   (INDEX_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_restart      (in_restart),
    .cmd             (cmd),
    .out_sample      (out_sample),
    .out_sample_index(out_sample_index),
    .out_last        (out_last)
  );

endmodule
